>>> hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and encode helpers for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

    localparam int unsigned SeqBytes     = 7;
    localparam int unsigned SeqBits      = SeqBytes * 8;
    localparam int unsigned CntBits      = $clog2(SeqBytes + 1);
    localparam int unsigned FifoDepthDef = 4;

    // replacement character, first byte in the lowest bits
    localparam logic [23:0] ReplSeq    = 24'hBD_BF_EF;
    localparam logic [20:0] SuppOffset = 21'h10000;
    localparam logic [7:0]  LeadTwo    = 8'hC0;
    localparam logic [7:0]  LeadThree  = 8'hE0;
    localparam logic [7:0]  LeadFour   = 8'hF0;
    localparam logic [7:0]  ContMark   = 8'h80;
    localparam logic [5:0]  HighSurTag = 6'b110110;
    localparam logic [5:0]  LowSurTag  = 6'b110111;

    // one queued group of bytes, byte 0 in the lowest bits
    typedef struct packed {
        logic [SeqBits-1:0] bytes;
        logic [CntBits-1:0] cnt;
        logic               term;
    } t_entry;

    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  cnt;
    } t_piece;

    function automatic logic is_high_sur(input logic [15:0] c);
        return c[15:10] == HighSurTag;
    endfunction

    function automatic logic is_low_sur(input logic [15:0] c);
        return c[15:10] == LowSurTag;
    endfunction

    // encode one unit with nothing held; a high surrogate gives no bytes
    function automatic t_piece encode_bmp(input logic [15:0] c);
        t_piece p;
        p = '0;
        if (c[15:7] == 9'd0) begin
            p.bytes = {16'h0000, c[7:0]};
            p.cnt   = 2'd1;
        end else if (c[15:11] == 5'd0) begin
            p.bytes = {8'h00, ContMark | {2'b00, c[5:0]}, LeadTwo | {3'b000, c[10:6]}};
            p.cnt   = 2'd2;
        end else if (is_high_sur(c)) begin
            p.cnt   = 2'd0;
        end else if (is_low_sur(c)) begin
            p.bytes = ReplSeq;
            p.cnt   = 2'd3;
        end else begin
            p.bytes = {ContMark | {2'b00, c[5:0]}, ContMark | {2'b00, c[11:6]},
                       LeadThree | {4'h0, c[15:12]}};
            p.cnt   = 2'd3;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hdl/utf16_to_utf8_encoder_core.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// UTF-16 code units in, UTF-8 bytes out, zero byte after the last unit.
//
//  channel  dir  tdata                 tlast        tuser
//  s        in   [15:0] code_unit      last_unit    -
//  m        out  [7:0]  out_byte       last_of_run  [0] terminator
//
// each unit gives 0 to 7 bytes, sent one per cycle by the back end while the
// receiver is ready.
// the front takes a word every cycle while the group queue has room.
// synchronous active-low reset empties the queue and drops a held surrogate.
// a stall on the output fills the queue, then the input ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_encoder_core
    import u16u8_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] code_unit
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic             o_m_tlast,
    output logic [0:0]       o_m_tuser    // [0] terminator
);

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    t_entry w_in_entry;
    t_entry w_head;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_code_unit (i_s_tdata),
        .i_last_unit (i_s_tlast),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_entry     (w_in_entry)
    );

    u16u8_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    u16u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_head  (w_head),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_last    (o_m_tlast),
        .o_term    (o_m_tuser[0])
    );

endmodule

`default_nettype wire

>>> hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Takes code units, pairs surrogates and builds the byte group of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_last_unit,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    logic       r_held_valid;
    logic [9:0] r_held_bits;
    logic       n_held_valid;

    logic        w_accept;
    logic        w_pair;
    logic [31:0] w_a_bytes;
    logic [2:0]  w_a_cnt;
    t_piece      w_b;
    t_piece      w_enc;
    logic [23:0] w_c_bytes;
    logic [1:0]  w_c_cnt;
    logic [20:0] w_cp;
    logic [2:0]  w_ab_cnt;
    logic [5:0]  w_off1;
    logic [5:0]  w_off2;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_pair   = r_held_valid && is_low_sur(i_code_unit);
    assign w_cp     = {1'b0, r_held_bits, i_code_unit[9:0]} + SuppOffset;
    assign w_enc    = encode_bmp(i_code_unit);

    always_comb begin
        w_a_bytes = '0;
        w_a_cnt   = 3'd0;
        w_b       = w_enc;
        if (w_pair) begin
            w_a_bytes = {ContMark | {2'b00, w_cp[5:0]}, ContMark | {2'b00, w_cp[11:6]},
                         ContMark | {2'b00, w_cp[17:12]}, LeadFour | {5'b00000, w_cp[20:18]}};
            w_a_cnt   = 3'd4;
            w_b       = '0;
        end else if (r_held_valid) begin
            w_a_bytes = {8'h00, ReplSeq};
            w_a_cnt   = 3'd3;
        end
        // a high surrogate on the last unit cannot wait
        if (i_last_unit && is_high_sur(i_code_unit)) begin
            w_c_bytes = ReplSeq;
            w_c_cnt   = 2'd3;
        end else begin
            w_c_bytes = '0;
            w_c_cnt   = 2'd0;
        end
    end

    assign w_ab_cnt = w_a_cnt + {1'b0, w_b.cnt};
    assign w_off1   = {w_a_cnt, 3'b000};
    assign w_off2   = {w_ab_cnt, 3'b000};

    // terminator byte is zero, so only its count slot is added
    always_comb begin
        o_entry.bytes = {{(SeqBits-32){1'b0}}, w_a_bytes}
                      | ({{(SeqBits-24){1'b0}}, w_b.bytes} << w_off1)
                      | ({{(SeqBits-24){1'b0}}, w_c_bytes} << w_off2);
        o_entry.cnt   = CntBits'(w_ab_cnt) + CntBits'(w_c_cnt) + CntBits'(i_last_unit);
        o_entry.term  = i_last_unit;
    end

    assign o_push       = w_accept && (o_entry.cnt != '0);
    assign n_held_valid = is_high_sur(i_code_unit) && !i_last_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (w_accept) begin
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held_bits <= i_code_unit[9:0];
        end
    end

`ifndef SYNTHESIS
    a_last_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_unit) |=> !r_held_valid)
        else $error("surrogate still held after last unit");
    a_only_hold_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !o_push) |=> r_held_valid)
        else $error("word dropped without holding a surrogate");
`endif

endmodule

`default_nettype wire

>>> hdl/u16u8_fifo.sv
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short queue of byte groups between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_fifo
    import u16u8_pkg::*;
#(
    parameter int unsigned DEPTH = FifoDepthDef
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_empty,
    output t_entry      o_head
);

    localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW    = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr;
    logic [CntW-1:0]    r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CntW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

>>> hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Pulls byte groups from the queue and sends them one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  t_entry      i_q_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last,
    output logic        o_term
);

    logic               r_valid;
    logic [SeqBits-1:0] r_bytes;
    logic [CntBits-1:0] r_left;
    logic               r_term;
    logic               w_fire;
    logic               w_final;

    assign o_valid = r_valid;
    assign o_byte  = r_bytes[7:0];
    assign w_final = (r_left == CntBits'(1));
    assign o_last  = w_final;
    assign o_term  = r_term && w_final;
    assign w_fire  = r_valid && i_ready;
    // load the next group as soon as the current one is done
    assign o_pop   = !i_q_empty && (!r_valid || (w_fire && w_final));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_left  <= i_q_head.cnt;
        end else if (w_fire) begin
            r_valid <= !w_final;
            r_left  <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= i_q_head.bytes;
            r_term  <= i_q_head.term;
        end else if (w_fire) begin
            r_bytes <= r_bytes >> 8;
        end
    end

`ifndef SYNTHESIS
    a_valid_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left != '0))
        else $error("output valid with no bytes left");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> tb/sv/utf16_to_utf8_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core_tb
// Self-checking bench for the UTF-16 to UTF-8 encoder core. Code units go
// in through the input stream in random bursts. A bit-level predictor works
// out the UTF-8 bytes for each accepted word and keeps them in a queue.
// Every byte taken from the output stream is checked field by field against
// the oldest entry in that queue. The receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_core_tb;
    import u16u8_pkg::*;

    localparam logic [15:0] HighSurFirst = 16'hD800;
    localparam logic [15:0] HighSurLast  = 16'hDBFF;
    localparam logic [15:0] LowSurFirst  = 16'hDC00;
    localparam logic [15:0] LowSurLast   = 16'hDFFF;
    localparam logic [15:0] OneByteMax   = 16'h007F;
    localparam logic [15:0] TwoByteMax   = 16'h07FF;

    localparam int RandUnits     = 195;
    localparam int RxHoldCycles  = 200;
    localparam int StallLimit    = 1500;
    localparam int TailCycles    = 24;
    localparam int MaxReports    = 30;

    typedef enum logic [1:0] {
        RX_FULL,
        RX_COIN,
        RX_SPARSE,
        RX_BUSY
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       term;
    } t_utf8_byte;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = 16'h0000;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    // predictor state
    logic        held_valid = 1'b0;
    logic [9:0]  held_bits = 10'd0;
    t_utf8_byte  pending_bytes[$];

    int errors = 0;
    int n_units = 0;
    int n_strings = 0;
    int n_pairs = 0;
    int n_repl = 0;
    int n_bytes = 0;
    int tx_burst_left = 0;
    int idle_cycles = 0;

    // receiver stall control
    int          rx_hold_reqs = 0;
    int          rx_hold_seen = 0;
    int          rx_hold_left = 0;
    t_rx_mode    rx_mode = RX_FULL;
    logic [5:0]  rx_cyc = 6'd0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utf16_to_utf8_encoder_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [15:0] code_unit
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] out_byte
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)     // [0] terminator
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic term);
        t_utf8_byte w;
        w.data = b;
        w.last = 1'b0;
        w.term = term;
        pending_bytes.push_back(w);
    endtask

    task automatic push_repl();
        push_byte(ReplSeq[7:0], 1'b0);
        push_byte(ReplSeq[15:8], 1'b0);
        push_byte(ReplSeq[23:16], 1'b0);
        n_repl++;
    endtask

    // encode with nothing held; a high surrogate gets held
    task automatic encode_plain(input logic [15:0] c);
        if (c <= OneByteMax) begin
            push_byte(c[7:0], 1'b0);
        end else if (c <= TwoByteMax) begin
            push_byte(LeadTwo | {3'b000, c[10:6]}, 1'b0);
            push_byte(ContMark | {2'b00, c[5:0]}, 1'b0);
        end else if (c >= HighSurFirst && c <= HighSurLast) begin
            held_valid = 1'b1;
            held_bits  = c[9:0];
        end else if (c >= LowSurFirst && c <= LowSurLast) begin
            push_repl();
        end else begin
            push_byte(LeadThree | {4'h0, c[15:12]}, 1'b0);
            push_byte(ContMark | {2'b00, c[11:6]}, 1'b0);
            push_byte(ContMark | {2'b00, c[5:0]}, 1'b0);
        end
    endtask

    task automatic predict_encoding(input logic [15:0] c, input logic lst);
        int          n0;
        logic [20:0] cp;
        n0 = pending_bytes.size();
        if (held_valid) begin
            held_valid = 1'b0;
            if (c >= LowSurFirst && c <= LowSurLast) begin
                cp = {1'b0, held_bits, c[9:0]} + SuppOffset;
                push_byte(LeadFour | {5'b00000, cp[20:18]}, 1'b0);
                push_byte(ContMark | {2'b00, cp[17:12]}, 1'b0);
                push_byte(ContMark | {2'b00, cp[11:6]}, 1'b0);
                push_byte(ContMark | {2'b00, cp[5:0]}, 1'b0);
                n_pairs++;
            end else begin
                push_repl();
                encode_plain(c);
            end
        end else begin
            encode_plain(c);
        end
        if (lst) begin
            // a high surrogate left dangling at the end of the string
            if (held_valid) begin
                held_valid = 1'b0;
                push_repl();
            end
            push_byte(8'h00, 1'b1);
            n_strings++;
        end
        if (pending_bytes.size() > n0)
            pending_bytes[$].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_unit(input logic [15:0] c, input logic lst);
        int   gap;
        logic taken;
        if (tx_burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            tx_burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        tx_burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        // inputs move only at rising edges, so ready at the falling edge
        // tells whether the next rising edge takes the word
        do begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        n_units++;
        predict_encoding(c, lst);
    endtask

    task automatic send_string(input logic [15:0] str[$]);
        foreach (str[i])
            send_unit(str[i], i == str.size() - 1);
    endtask

    // stop offering and wait for every pending byte
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side: stall pattern and checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= RxHoldCycles;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            rx_cyc <= rx_cyc + 6'd1;
            if (rx_cyc == 6'd0)
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_FULL:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= (rx_cyc[1:0] == 2'd0);
                default:   m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(negedge clk) begin
        t_utf8_byte want;
        if (rst_n && m_tvalid && m_tready) begin
            n_bytes++;
            if (pending_bytes.size() == 0) begin
                errors++;
                if (errors <= MaxReports)
                    $display("%0t: unexpected byte data=%02h last=%b term=%b",
                             $time, m_tdata, m_tlast, m_tuser[0]);
            end else begin
                want = pending_bytes.pop_front();
                if (want.data !== m_tdata || want.last !== m_tlast ||
                    want.term !== m_tuser[0]) begin
                    errors++;
                    if (errors <= MaxReports)
                        $display({"%0t: mismatch expected data=%02h last=%b term=%b,",
                                  " got data=%02h last=%b term=%b"},
                                 $time, want.data, want.last, want.term,
                                 m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(negedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= StallLimit) begin
            $display("%0t: timeout, %0d bytes still pending", $time, pending_bytes.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_length_bounds();
        logic [15:0] str[$];
        // zero unit as data, then every length boundary
        str = '{16'h0000, 16'h0001, OneByteMax, 16'h0080, TwoByteMax, 16'h0800,
                16'hD7FF, 16'hE000, 16'hFFFF};
        send_string(str);
        str = '{16'h0000};
        send_string(str);
    endtask

    task automatic test_surrogates();
        logic [15:0] str[$];
        // pairs at both ends of the supplementary range
        str = '{HighSurFirst, LowSurFirst, HighSurLast, LowSurLast};
        send_string(str);
        // lone low, high followed by ascii, high followed by another high
        str = '{LowSurFirst, 16'hD9AB, 16'h0041, HighSurFirst, HighSurLast, 16'hDEAD};
        send_string(str);
        // high surrogate as the last unit, alone and after a held high
        str = '{16'hDBC0};
        send_string(str);
        str = '{16'hD801, 16'hDA55};
        send_string(str);
        // held high, then a plain last unit
        str = '{16'hD801, 16'h0042};
        send_string(str);
    endtask

    task automatic make_string(output logic [15:0] str[$]);
        int          len;
        int          kind;
        logic [15:0] c;
        str = {};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
        while (str.size() < len) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                str.push_back(16'($urandom_range(0, OneByteMax)));
            end else if (kind < 45) begin
                str.push_back(16'($urandom_range(OneByteMax + 1, TwoByteMax)));
            end else if (kind < 65) begin
                c = 16'($urandom_range(TwoByteMax + 1, 16'hFFFF));
                if (c >= HighSurFirst && c <= LowSurLast)
                    c = c ^ 16'h2000;
                str.push_back(c);
            end else if (kind < 88) begin
                str.push_back(16'($urandom_range(HighSurFirst, HighSurLast)));
                str.push_back(16'($urandom_range(LowSurFirst, LowSurLast)));
            end else if (kind < 93) begin
                str.push_back(16'($urandom_range(LowSurFirst, LowSurLast)));
            end else if (kind < 97) begin
                str.push_back(16'($urandom_range(HighSurFirst, HighSurLast)));
            end else begin
                str.push_back(16'($urandom()));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering three-byte units
    task automatic test_output_backpressure();
        logic [15:0] str[$];
        rx_hold_reqs <= rx_hold_reqs + 1;
        str = {};
        repeat (15)
            str.push_back(16'($urandom_range(16'h1000, 16'hCFFF)));
        send_string(str);
        wait_drained();
    endtask

    task automatic test_random_strings();
        logic [15:0] str[$];
        int          start;
        start = n_units;
        while (n_units - start < RandUnits) begin
            make_string(str);
            send_string(str);
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_length_bounds();
        test_surrogates();
        wait_drained();
        test_output_backpressure();
        test_random_strings();
        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (pending_bytes.size() != 0) begin
            errors++;
            $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
        end
        $display("covered %0d code units in %0d strings, %0d surrogate pairs, %0d replacements",
                 n_units, n_strings, n_pairs, n_repl);
        $display("%0d output bytes checked under receiver hold-off and random stalls",
                 n_bytes);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
